// ----- hw/rtl/ps2kd_pkg.sv -----
// Shared types, key numbers and lookup functions for the PS/2 set 2 key decoder.
// No dependencies; the top level, the front end and the back end import this package.
package ps2kd_pkg;

  // Result classes of one received byte.
  typedef enum logic [1:0] {
    OUT_ABSORBED    = 2'd0,
    OUT_KEY         = 2'd1,
    OUT_UNSUPPORTED = 2'd2
  } outcome_t;

  // Prefix and control bytes of scan code set 2.
  localparam logic [7:0] SC_EXTENDED = 8'he0;
  localparam logic [7:0] SC_BREAK    = 8'hf0;
  localparam logic [7:0] SC_PAUSE    = 8'he1;
  localparam logic [2:0] PAUSE_TAIL  = 3'd7;

  // Held bitmap geometry: one bit per extended flag and code.
  localparam int MAP_DEPTH = 512;
  localparam int MAP_AW    = 9;

  // Special key numbers.
  localparam logic [7:0] KEY_NONE      = 8'd0;
  localparam logic [7:0] KEY_BACKSPACE = 8'd128;
  localparam logic [7:0] KEY_ENTER     = 8'd129;
  localparam logic [7:0] KEY_ESCAPE    = 8'd130;
  localparam logic [7:0] KEY_LEFT      = 8'd131;
  localparam logic [7:0] KEY_RIGHT     = 8'd132;
  localparam logic [7:0] KEY_UP        = 8'd133;
  localparam logic [7:0] KEY_DN        = 8'd134;
  localparam logic [7:0] KEY_LSHIFT    = 8'd135;
  localparam logic [7:0] KEY_RSHIFT    = 8'd136;
  localparam logic [7:0] KEY_LCTRL     = 8'd137;
  localparam logic [7:0] KEY_RCTRL     = 8'd138;
  localparam logic [7:0] KEY_LALT      = 8'd139;
  localparam logic [7:0] KEY_RALT      = 8'd140;
  localparam logic [7:0] KEY_CAPS      = 8'd141;

  // Classified request passed from the front end to the back end.
  typedef struct packed {
    outcome_t           kind;
    logic [7:0]         key;
    logic [MAP_AW-1:0]  idx;
    logic               rel;
    logic [63:0]        ts;
  } mid_item_t;

  // Finished result as delivered on the output ports.
  typedef struct packed {
    logic [1:0]  outcome;
    logic [7:0]  key_code;
    logic [6:0]  text_char;
    logic        pressed;
    logic        is_repeat;
    logic        shift_active;
    logic        control_active;
    logic        alt_active;
    logic        caps_active;
    logic [63:0] event_time;
  } out_item_t;

  // Map a scan code to a key number; zero means the code is not supported.
  function automatic logic [7:0] map_code(input logic [7:0] code, input logic ext);
    logic [7:0] k;
    k = KEY_NONE;
    if (ext) begin
      case (code)
        8'h6b:   k = KEY_LEFT;
        8'h74:   k = KEY_RIGHT;
        8'h75:   k = KEY_UP;
        8'h72:   k = KEY_DN;
        8'h14:   k = KEY_RCTRL;
        8'h11:   k = KEY_RALT;
        default: k = KEY_NONE;
      endcase
    end else begin
      case (code)
        8'h66:   k = KEY_BACKSPACE;
        8'h5a:   k = KEY_ENTER;
        8'h76:   k = KEY_ESCAPE;
        8'h29:   k = 8'h20;
        8'h12:   k = KEY_LSHIFT;
        8'h59:   k = KEY_RSHIFT;
        8'h14:   k = KEY_LCTRL;
        8'h11:   k = KEY_LALT;
        8'h58:   k = KEY_CAPS;
        8'h1c:   k = 8'h61;
        8'h32:   k = 8'h62;
        8'h21:   k = 8'h63;
        8'h23:   k = 8'h64;
        8'h24:   k = 8'h65;
        8'h2b:   k = 8'h66;
        8'h34:   k = 8'h67;
        8'h33:   k = 8'h68;
        8'h43:   k = 8'h69;
        8'h3b:   k = 8'h6a;
        8'h42:   k = 8'h6b;
        8'h4b:   k = 8'h6c;
        8'h3a:   k = 8'h6d;
        8'h31:   k = 8'h6e;
        8'h44:   k = 8'h6f;
        8'h4d:   k = 8'h70;
        8'h15:   k = 8'h71;
        8'h2d:   k = 8'h72;
        8'h1b:   k = 8'h73;
        8'h2c:   k = 8'h74;
        8'h3c:   k = 8'h75;
        8'h2a:   k = 8'h76;
        8'h1d:   k = 8'h77;
        8'h22:   k = 8'h78;
        8'h35:   k = 8'h79;
        8'h1a:   k = 8'h7a;
        8'h16:   k = 8'h31;
        8'h1e:   k = 8'h32;
        8'h26:   k = 8'h33;
        8'h25:   k = 8'h34;
        8'h2e:   k = 8'h35;
        8'h36:   k = 8'h36;
        8'h3d:   k = 8'h37;
        8'h3e:   k = 8'h38;
        8'h46:   k = 8'h39;
        8'h45:   k = 8'h30;
        8'h0e:   k = 8'h60;
        8'h4e:   k = 8'h2d;
        8'h55:   k = 8'h3d;
        8'h54:   k = 8'h5b;
        8'h5b:   k = 8'h5d;
        8'h5d:   k = 8'h5c;
        8'h4c:   k = 8'h3b;
        8'h52:   k = 8'h27;
        8'h41:   k = 8'h2c;
        8'h49:   k = 8'h2e;
        8'h4a:   k = 8'h2f;
        default: k = KEY_NONE;
      endcase
    end
    return k;
  endfunction

  // Printable text of a pressed key after the shift and caps lock rules.
  function automatic logic [6:0] text_of(input logic [7:0] key, input logic shift,
                                         input logic caps);
    logic [7:0] t;
    logic [7:0] up;
    logic       is_sym;
    is_sym = 1'b1;
    case (key)
      8'h60:   up = 8'h7e;
      8'h31:   up = 8'h21;
      8'h32:   up = 8'h40;
      8'h33:   up = 8'h23;
      8'h34:   up = 8'h24;
      8'h35:   up = 8'h25;
      8'h36:   up = 8'h5e;
      8'h37:   up = 8'h26;
      8'h38:   up = 8'h2a;
      8'h39:   up = 8'h28;
      8'h30:   up = 8'h29;
      8'h2d:   up = 8'h5f;
      8'h3d:   up = 8'h2b;
      8'h5b:   up = 8'h7b;
      8'h5d:   up = 8'h7d;
      8'h5c:   up = 8'h7c;
      8'h3b:   up = 8'h3a;
      8'h27:   up = 8'h22;
      8'h2c:   up = 8'h3c;
      8'h2e:   up = 8'h3e;
      8'h2f:   up = 8'h3f;
      default: begin
        up     = key;
        is_sym = 1'b0;
      end
    endcase
    if (key inside {[8'h61:8'h7a]}) begin
      // Letters go upper case when exactly one of shift and caps lock is on.
      t = (shift ^ caps) ? (key - 8'h20) : key;
    end else if (is_sym) begin
      t = shift ? up : key;
    end else if (key inside {[8'h20:8'h7e]}) begin
      t = key;
    end else begin
      t = 8'h00;
    end
    return t[6:0];
  endfunction

endpackage

// ----- hw/rtl/ps2_scan_set2_key_decoder.sv -----
// Top level of the PS/2 scan code set 2 key decoder.
// Depends on ps2kd_pkg, ps2kd_front, ps2kd_fifo and ps2kd_back.
//
//   Channel   Handshake          Payload
//   input     in_push / in_full  in_scan_byte, in_timestamp
//   result    out_pop / out_empty out_outcome .. out_event_time (one per byte)
//
// One byte is accepted per cycle while in_full is low, and each byte gives exactly
// one result; the bitmap read-modify-write in the back end sets that rate, with a
// bypass for back-to-back events on the same key. A result passes the stage queue,
// the back end stage register and the result queue on its way to the result ports.
// After reset the 512-entry held bitmap is cleared, with in_full high. A stalled
// result side fills the result queue, the back end stage register and then the
// stage queue before in_full rises.
module ps2_scan_set2_key_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_scan_byte,
  input  logic [63:0] in_timestamp,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_outcome,
  output logic [7:0]  out_key_code,
  output logic [6:0]  out_text_char,
  output logic        out_pressed,
  output logic        out_is_repeat,
  output logic        out_shift_active,
  output logic        out_control_active,
  output logic        out_alt_active,
  output logic        out_caps_active,
  output logic [63:0] out_event_time
);

  import ps2kd_pkg::*;

  logic      mid_full, mid_empty, mid_push, mid_pop, clearing;
  mid_item_t front_item, mid_item;
  out_item_t res;

  assign in_full = mid_full || clearing;

  // Front end classifies each accepted byte.
  ps2kd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_scan_byte (in_scan_byte),
    .in_timestamp (in_timestamp),
    .stall        (in_full),
    .q_push       (mid_push),
    .q_item       (front_item)
  );

  // Stage queue between front and back end.
  ps2kd_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  // Back end carries out key events and queues results.
  ps2kd_back #(
    .OUT_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (mid_empty),
    .q_item    (mid_item),
    .q_pop     (mid_pop),
    .clearing  (clearing),
    .out_item  (res),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  // Result fields onto their own ports.
  assign out_outcome        = res.outcome;
  assign out_key_code       = res.key_code;
  assign out_text_char      = res.text_char;
  assign out_pressed        = res.pressed;
  assign out_is_repeat      = res.is_repeat;
  assign out_shift_active   = res.shift_active;
  assign out_control_active = res.control_active;
  assign out_alt_active     = res.alt_active;
  assign out_caps_active    = res.caps_active;
  assign out_event_time     = res.event_time;

endmodule

// ----- hw/rtl/ps2kd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ps2kd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, and a read that holds its data until the next read enable.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ps2kd_fifo.sv -----
// Small register-based queue with push/full and pop/empty handshakes.
// No dependencies; used between the decoder stages and at the output.
module ps2kd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/ps2kd_front.sv -----
// Front end: accepts scan bytes, tracks prefixes and the Pause tail, maps codes.
// Depends on ps2kd_pkg; feeds the stage queue toward ps2kd_back.
module ps2kd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [7:0]            in_scan_byte,
  input  logic [63:0]           in_timestamp,
  input  logic                  stall,
  output logic                  q_push,
  output ps2kd_pkg::mid_item_t  q_item
);

  import ps2kd_pkg::*;

  logic [2:0] pause_cnt_r, pause_cnt_nxt;
  logic       ext_r, ext_nxt;
  logic       brk_r, brk_nxt;
  logic [7:0] key;

  assign q_push = in_push && !stall;
  assign key    = map_code(in_scan_byte, ext_r);

  // Classify the byte and work out the prefix state that it leaves.
  always_comb begin
    pause_cnt_nxt = pause_cnt_r;
    ext_nxt       = ext_r;
    brk_nxt       = brk_r;
    q_item.kind   = OUT_ABSORBED;
    q_item.key    = key;
    q_item.idx    = {ext_r, in_scan_byte};
    q_item.rel    = brk_r;
    q_item.ts     = in_timestamp;
    if (pause_cnt_r != 3'd0) begin
      pause_cnt_nxt = pause_cnt_r - 3'd1;
    end else if (in_scan_byte == SC_EXTENDED) begin
      ext_nxt = 1'b1;
    end else if (in_scan_byte == SC_BREAK) begin
      brk_nxt = 1'b1;
    end else if (in_scan_byte == SC_PAUSE) begin
      ext_nxt       = 1'b0;
      brk_nxt       = 1'b0;
      pause_cnt_nxt = PAUSE_TAIL;
    end else begin
      ext_nxt     = 1'b0;
      brk_nxt     = 1'b0;
      q_item.kind = (key == KEY_NONE) ? OUT_UNSUPPORTED : OUT_KEY;
    end
  end

  // Prefix state changes only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_cnt_r <= '0;
      ext_r       <= 1'b0;
      brk_r       <= 1'b0;
    end else if (q_push) begin
      pause_cnt_r <= pause_cnt_nxt;
      ext_r       <= ext_nxt;
      brk_r       <= brk_nxt;
    end
  end

endmodule

// ----- hw/rtl/ps2kd_back.sv -----
// Back end: held bitmap read-modify-write, modifiers, caps lock, text, result queue.
// Depends on ps2kd_pkg, ps2kd_ram and ps2kd_fifo.
module ps2kd_back #(
  parameter int OUT_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  ps2kd_pkg::mid_item_t  q_item,
  output logic                  q_pop,
  output logic                  clearing,
  output ps2kd_pkg::out_item_t  out_item,
  output logic                  out_empty,
  input  logic                  out_pop
);

  import ps2kd_pkg::*;

  localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(MAP_DEPTH - 1);

  logic              clr_active_r;
  logic [MAP_AW-1:0] clr_cnt_r;
  logic              s1_valid_r, s1_valid_nxt;
  mid_item_t         s1_item_r;
  logic              byp_r, byp_val_r;
  logic [5:0]        mods_r, mods_nxt;
  logic              caps_r, caps_nxt;
  logic              ofull, s1_fire, is_key, held, rep, key_wr;
  logic              ram_we, ram_wdata, ram_rdata;
  logic [MAP_AW-1:0] ram_waddr;
  logic [5:0]        mod_bit;
  logic              shift;
  out_item_t         res;

  assign clearing = clr_active_r;
  assign s1_fire  = s1_valid_r && !ofull;
  assign q_pop    = !clr_active_r && !q_empty && (!s1_valid_r || s1_fire);
  assign is_key   = (s1_item_r.kind == OUT_KEY);
  assign held     = byp_r ? byp_val_r : ram_rdata;
  assign rep      = is_key && !s1_item_r.rel && held;
  assign key_wr   = s1_fire && is_key;

  // Clearing pass over the bitmap after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + MAP_AW'(1);
      if (clr_cnt_r == CLR_LAST) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Bitmap write port: cleared during the pass, then one key event per cycle while the result queue takes results.
  always_comb begin
    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = key_wr;
      ram_waddr = s1_item_r.idx;
      ram_wdata = !s1_item_r.rel;
    end
  end

  ps2kd_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_item.idx),
    .rdata (ram_rdata)
  );

  // Modifier bit that the key drives, if any.
  always_comb begin
    case (s1_item_r.key)
      KEY_LSHIFT: mod_bit = 6'b000001;
      KEY_RSHIFT: mod_bit = 6'b000010;
      KEY_LCTRL:  mod_bit = 6'b000100;
      KEY_RCTRL:  mod_bit = 6'b001000;
      KEY_LALT:   mod_bit = 6'b010000;
      KEY_RALT:   mod_bit = 6'b100000;
      default:    mod_bit = 6'b000000;
    endcase
  end

  // New modifier and caps lock state after this key event.
  always_comb begin
    mods_nxt = s1_item_r.rel ? (mods_r & ~mod_bit) : (mods_r | mod_bit);
    caps_nxt = caps_r ^ ((s1_item_r.key == KEY_CAPS) && !s1_item_r.rel && !rep);
  end

  assign shift = (mods_nxt[1:0] != 2'b00);

  // Assemble the result; absorbed and unsupported bytes carry only class and time.
  always_comb begin
    res            = '0;
    res.outcome    = s1_item_r.kind;
    res.event_time = s1_item_r.ts;
    if (is_key) begin
      res.key_code       = s1_item_r.key;
      res.text_char      = s1_item_r.rel ? 7'd0 : text_of(s1_item_r.key, shift, caps_nxt);
      res.pressed        = !s1_item_r.rel;
      res.is_repeat      = rep;
      res.shift_active   = shift;
      res.control_active = (mods_nxt[3:2] != 2'b00);
      res.alt_active     = (mods_nxt[5:4] != 2'b00);
      res.caps_active    = caps_nxt;
    end
  end

  // Stage register control; the item waits here for its bitmap read data.
  always_comb begin
    if (q_pop) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
      mods_r     <= '0;
      caps_r     <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      // A read that meets a write to the same entry takes the written value.
      if (q_pop) begin
        byp_r <= key_wr && (q_item.idx == s1_item_r.idx);
      end
      if (key_wr) begin
        mods_r <= mods_nxt;
        caps_r <= caps_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
      byp_val_r <= !s1_item_r.rel;
    end
  end

  // Result queue parts the back end from the consumer.
  ps2kd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s1_fire),
    .wdata (res),
    .full  (ofull),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule
